// ----- rtl/hlf_pkg.sv -----
// ---------------------------------------------------------------------------
// Harmonic lens field evaluator package
// Shared item types, register indexes, constants and rounding helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package hlf_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int CORDIC_GAIN       = 652032874;

	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [31:0] PI2_Q28 = 32'd2649351758;

	localparam int unsigned SH_DEFL  = 76;
	localparam int unsigned SH_DERIV = 90;
	localparam int unsigned SH_DENS  = 30;

	localparam logic [2:0] REG_DENSITY_SCALE = 3'd0;
	localparam logic [2:0] REG_WAVE_K        = 3'd1;
	localparam logic [2:0] REG_WAVE_L        = 3'd2;
	localparam logic [2:0] REG_PHASE_X       = 3'd3;
	localparam logic [2:0] REG_PHASE_Y       = 3'd4;
	localparam logic [2:0] REG_LENS_FACTOR   = 3'd5;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        src_dist;
		logic [31:0]        lens_src_dist;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] defl_x;
		logic signed [31:0] defl_y;
		logic signed [31:0] deriv_xx;
		logic signed [31:0] deriv_yy;
		logic signed [31:0] deriv_xy;
		logic signed [31:0] density;
		logic signed [31:0] potential;
		logic               div_error;
	} out_item_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2F9;
			15: r = 32'h0000517C;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A2F;
			19: r = 32'h00000517;
			20: r = 32'h0000028B;
			21: r = 32'h00000145;
			22: r = 32'h000000A2;
			23: r = 32'h00000051;
			24: r = 32'h00000028;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000002;
			29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// Rounds a magnitude to nearest with ties away from zero, applies the sign
	// and saturates to the signed 32-bit range.
	function automatic logic [31:0] round_sat(input logic [159:0] p, input int unsigned sh,
		input logic neg);
		logic [160:0] t;
		logic         big;
		logic [31:0]  r;
		t = ({1'b0, p} + (161'(1) << (sh - 1))) >> sh;
		big = |t[160:32];
		if (neg) begin
			r = (big || t[31:0] > 32'h8000_0000) ? 32'h8000_0000 : 32'(-t[31:0]);
		end else begin
			r = (big || t[31]) ? 32'h7FFF_FFFF : t[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/harmonic_lens_field_eval_core.sv -----
// ---------------------------------------------------------------------------
// Harmonic lens field evaluator
// Evaluates deflection, its derivatives, density and scaled potential of a
// harmonic lens at one sky position per item.
// ---------------------------------------------------------------------------
// Items enter on in_valid/in_ready and leave on out_valid/out_ready; each
// input item gives exactly one result item, in order.
// The block takes one item per cycle unless the receiver stalls the output.
// The pipeline holds two phase stages, the CORDIC rotations plus a quadrant
// stage, two trig product stages, then the potential path with its two wide
// multiplies, a scaling stage and a 34-stage restoring divider, which sets the depth.
// The other results wait in a delay line to leave together with the potential.
// in_ready is high while the output register is empty or being taken; when
// the receiver stalls, the whole pipeline holds and nothing is lost.
// Configuration writes on cfg_valid/cfg_data are always accepted; the user must make
// them while the block is idle, which the block does not enforce. Register indexes
// above 5 are ignored. Reset clears the config and delay lines, emptying the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module harmonic_lens_field_eval_core
	import hlf_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int NI   = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int BASE = NI + 5;
	localparam int LAT  = BASE + 40;
	localparam int TSC  = 0;
	localparam int TCS  = 1;
	localparam int TCC  = 2;
	localparam int TSS  = 3;

	logic adv;

	logic signed [31:0] density_scale_q;
	logic signed [31:0] wave_k_q;
	logic signed [31:0] wave_l_q;
	logic [31:0]        phase_x_q;
	logic [31:0]        phase_y_q;
	logic signed [31:0] lens_factor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_scale_q <= '0;
			wave_k_q        <= '0;
			wave_l_q        <= '0;
			phase_x_q       <= '0;
			phase_y_q       <= '0;
			lens_factor_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DENSITY_SCALE: density_scale_q <= cfg_data;
				REG_WAVE_K:        wave_k_q        <= cfg_data;
				REG_WAVE_L:        wave_l_q        <= cfg_data;
				REG_PHASE_X:       phase_x_q       <= cfg_data;
				REG_PHASE_Y:       phase_y_q       <= cfg_data;
				REG_LENS_FACTOR:   lens_factor_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Amplitudes that depend on the registers alone come from free-running multipliers.
	logic [31:0]  mag_f;
	logic [31:0]  mag_k;
	logic [31:0]  mag_l;
	logic [31:0]  mag_s;
	logic [63:0]  fk;
	logic [63:0]  fl;
	logic [63:0]  fp2;
	logic [95:0]  amp_x;
	logic [95:0]  amp_y;
	logic [95:0]  fp2k;
	logic [95:0]  fp2l;
	logic [127:0] amp_xx;
	logic [127:0] amp_yy;
	logic [127:0] amp_xy;
	logic         nf;
	logic         nk;
	logic         nl;
	logic         ns;

	assign mag_f = mag32(lens_factor_q);
	assign mag_k = mag32(wave_k_q);
	assign mag_l = mag32(wave_l_q);
	assign mag_s = mag32(density_scale_q);
	assign nf    = lens_factor_q[31];
	assign nk    = wave_k_q[31];
	assign nl    = wave_l_q[31];
	assign ns    = density_scale_q[31];

	hlf_wmul #(.NL(1)) u_fk   (.clk, .en(1'b1), .a(mag_f), .b(mag_k),   .p(fk));
	hlf_wmul #(.NL(1)) u_fl   (.clk, .en(1'b1), .a(mag_f), .b(mag_l),   .p(fl));
	hlf_wmul #(.NL(1)) u_fp2  (.clk, .en(1'b1), .a(mag_f), .b(PI2_Q28), .p(fp2));
	hlf_wmul #(.NL(2)) u_ampx (.clk, .en(1'b1), .a(fk),    .b(PI_Q30),  .p(amp_x));
	hlf_wmul #(.NL(2)) u_ampy (.clk, .en(1'b1), .a(fl),    .b(PI_Q30),  .p(amp_y));
	hlf_wmul #(.NL(2)) u_fp2k (.clk, .en(1'b1), .a(fp2),   .b(mag_k),   .p(fp2k));
	hlf_wmul #(.NL(2)) u_fp2l (.clk, .en(1'b1), .a(fp2),   .b(mag_l),   .p(fp2l));
	hlf_wmul #(.NL(3)) u_axx  (.clk, .en(1'b1), .a(fp2k),  .b(mag_k),   .p(amp_xx));
	hlf_wmul #(.NL(3)) u_ayy  (.clk, .en(1'b1), .a(fp2l),  .b(mag_l),   .p(amp_yy));
	hlf_wmul #(.NL(3)) u_axy  (.clk, .en(1'b1), .a(fp2k),  .b(mag_l),   .p(amp_xy));

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	hlf_delay #(.W(1), .D(LAT)) u_vld (
		.clk, .arst_n, .en(adv), .din(in_valid), .dout(out_valid)
	);

	// Phase stages.
	logic signed [63:0] prodx_s1;
	logic signed [63:0] prody_s1;
	logic [31:0]        u_s2;
	logic [31:0]        v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			prodx_s1 <= 64'(wave_k_q) * 64'(in_data.pos_x);
			prody_s1 <= 64'(wave_l_q) * 64'(in_data.pos_y);
			u_s2     <= prodx_s1[32:1] + phase_x_q;
			v_s2     <= prody_s1[32:1] + phase_y_q;
		end
	end

	logic signed [31:0] cos_u;
	logic signed [31:0] sin_u;
	logic signed [31:0] cos_v;
	logic signed [31:0] sin_v;

	hlf_cordic #(.STAGES(CORDIC_STAGES)) u_cu (
		.clk, .en(adv), .ang(u_s2), .cos_val(cos_u), .sin_val(sin_u)
	);
	hlf_cordic #(.STAGES(CORDIC_STAGES)) u_cv (
		.clk, .en(adv), .ang(v_s2), .cos_val(cos_v), .sin_val(sin_v)
	);

	// Trig products rounded to Q2.30.
	logic signed [63:0] prod_s3 [4];
	logic [30:0]        mag_s4 [4];
	logic               neg_s4 [4];
	logic [63:0]        pm [4];
	logic [63:0]        rnd [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3[TSC] <= 64'(sin_u) * 64'(cos_v);
			prod_s3[TCS] <= 64'(cos_u) * 64'(sin_v);
			prod_s3[TCC] <= 64'(cos_u) * 64'(cos_v);
			prod_s3[TSS] <= 64'(sin_u) * 64'(sin_v);
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pm[i]  = prod_s3[i][63] ? 64'(-prod_s3[i]) : 64'(prod_s3[i]);
			rnd[i] = (pm[i] + 64'(1 << 29)) >> 30;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				mag_s4[i] <= rnd[i][30:0];
				neg_s4[i] <= prod_s3[i][63];
			end
		end
	end

	// Distances aligned with the trig products.
	logic [63:0] dist_b;
	logic [31:0] ds_b;
	logic [31:0] dds_b;

	hlf_delay #(.W(64), .D(BASE)) u_dist (
		.clk, .arst_n, .en(adv),
		.din({in_data.src_dist, in_data.lens_src_dist}), .dout(dist_b)
	);
	assign ds_b  = dist_b[63:32];
	assign dds_b = dist_b[31:0];

	logic [31:0] m_sc;
	logic [31:0] m_cs;
	logic [31:0] m_cc;
	logic [31:0] m_ss;

	assign m_sc = {1'b0, mag_s4[TSC]};
	assign m_cs = {1'b0, mag_s4[TCS]};
	assign m_cc = {1'b0, mag_s4[TCC]};
	assign m_ss = {1'b0, mag_s4[TSS]};

	logic [5:0] sgn_b;
	logic [5:0] sgn_d;

	assign sgn_b[0] = nf ^ nk ^ neg_s4[TSC];
	assign sgn_b[1] = nf ^ nl ^ neg_s4[TCS];
	assign sgn_b[2] = nf ^ neg_s4[TCC];
	assign sgn_b[3] = nf ^ neg_s4[TCC];
	assign sgn_b[4] = ~(nf ^ nk ^ nl ^ neg_s4[TSS]);
	assign sgn_b[5] = ns ^ neg_s4[TCC];

	hlf_delay #(.W(6), .D(2)) u_sgn (
		.clk, .arst_n, .en(adv), .din(sgn_b), .dout(sgn_d)
	);

	logic [127:0] p_dx;
	logic [127:0] p_dy;
	logic [159:0] p_xx;
	logic [159:0] p_yy;
	logic [159:0] p_xy;
	logic [63:0]  p_den;

	hlf_wmul #(.NL(3)) u_mdx  (.clk, .en(adv), .a(amp_x),  .b(m_sc), .p(p_dx));
	hlf_wmul #(.NL(3)) u_mdy  (.clk, .en(adv), .a(amp_y),  .b(m_cs), .p(p_dy));
	hlf_wmul #(.NL(4)) u_mxx  (.clk, .en(adv), .a(amp_xx), .b(m_cc), .p(p_xx));
	hlf_wmul #(.NL(4)) u_myy  (.clk, .en(adv), .a(amp_yy), .b(m_cc), .p(p_yy));
	hlf_wmul #(.NL(4)) u_mxy  (.clk, .en(adv), .a(amp_xy), .b(m_ss), .p(p_xy));
	hlf_wmul #(.NL(1)) u_mden (.clk, .en(adv), .a(mag_s),  .b(m_cc), .p(p_den));

	logic [191:0] res_b;
	logic [191:0] res_d;

	assign res_b = {
		round_sat(160'(p_dx), SH_DEFL, sgn_d[0]),
		round_sat(160'(p_dy), SH_DEFL, sgn_d[1]),
		round_sat(p_xx, SH_DERIV, sgn_d[2]),
		round_sat(p_yy, SH_DERIV, sgn_d[3]),
		round_sat(p_xy, SH_DERIV, sgn_d[4]),
		round_sat(160'(p_den), SH_DENS, sgn_d[5])
	};

	hlf_delay #(.W(192), .D(37)) u_res (
		.clk, .arst_n, .en(adv), .din(res_b), .dout(res_d)
	);

	// Potential: round(F*T*Dds / (Ds * 2^30)) through a pipelined divider.
	logic [1:0]  pflg_d;
	logic [31:0] dds_d2;
	logic [31:0] ds_d4;
	logic [63:0] p_ft;
	logic [95:0] p_ftd;
	logic [97:0] xsum;
	logic [65:0] y_s;
	logic [31:0] ds_y_s;
	logic [32:0] quo;
	logic        ovf;

	hlf_delay #(.W(2), .D(39)) u_pflg (
		.clk, .arst_n, .en(adv),
		.din({ds_b == 32'd0, ~(nf ^ neg_s4[TCC])}), .dout(pflg_d)
	);
	hlf_delay #(.W(32), .D(2)) u_dds (
		.clk, .arst_n, .en(adv), .din(dds_b), .dout(dds_d2)
	);
	hlf_delay #(.W(32), .D(4)) u_ds (
		.clk, .arst_n, .en(adv), .din(ds_b), .dout(ds_d4)
	);

	hlf_wmul #(.NL(1)) u_mft  (.clk, .en(adv), .a(mag_f), .b(m_cc),   .p(p_ft));
	hlf_wmul #(.NL(2)) u_mftd (.clk, .en(adv), .a(p_ft),  .b(dds_d2), .p(p_ftd));

	assign xsum = {1'b0, p_ftd, 1'b0} + {36'b0, ds_d4, 30'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s    <= xsum[96:31];
			ds_y_s <= ds_d4;
		end
	end

	hlf_div u_div (
		.clk, .en(adv), .num(y_s), .den(ds_y_s), .quo, .ovf
	);

	logic        big;
	logic [31:0] pot;

	always_comb begin
		big = ovf | quo[32];
		if (pflg_d[1]) begin
			pot = '0;
		end else if (pflg_d[0]) begin
			pot = (big || quo[31:0] > 32'h8000_0000) ? 32'h8000_0000 : 32'(-quo[31:0]);
		end else begin
			pot = (big || quo[31]) ? 32'h7FFF_FFFF : quo[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.defl_x    <= res_d[191:160];
			out_data.defl_y    <= res_d[159:128];
			out_data.deriv_xx  <= res_d[127:96];
			out_data.deriv_yy  <= res_d[95:64];
			out_data.deriv_xy  <= res_d[63:32];
			out_data.density   <= res_d[31:0];
			out_data.potential <= pot;
			out_data.div_error <= pflg_d[1];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hlf_delay.sv -----
// ---------------------------------------------------------------------------
// Harmonic lens delay line
// Fixed-depth register chain that advances with the pipeline enable.
// ---------------------------------------------------------------------------
`default_nettype none

module hlf_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] dly_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) dly_q[i] <= '0;
		end else if (en) begin
			dly_q[0] <= din;
			for (int i = 1; i < D; i++) dly_q[i] <= dly_q[i-1];
		end
	end

	assign dout = dly_q[D-1];

endmodule

`default_nettype wire

// ----- rtl/hlf_wmul.sv -----
// ---------------------------------------------------------------------------
// Harmonic lens wide multiplier
// Multiplies a multi-word operand by a 32-bit word: one stage of 32x32
// partial products, one stage that sums them.
// ---------------------------------------------------------------------------
`default_nettype none

module hlf_wmul #(
	parameter int NL = 1
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [NL*32-1:0]  a,
	input  wire logic [31:0]       b,
	output logic      [NL*32+31:0] p
);

	localparam int PW = NL * 32 + 32;

	logic [63:0]   pp_s1 [NL];
	logic [PW-1:0] sum;
	logic [PW-1:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NL; j++) pp_s1[j] <= 64'(a[j*32 +: 32]) * 64'(b);
		end
	end

	always_comb begin
		sum = '0;
		for (int j = 0; j < NL; j++) sum = sum + (PW'(pp_s1[j]) << (32 * j));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= sum;
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

// ----- rtl/hlf_cordic.sv -----
// ---------------------------------------------------------------------------
// Harmonic lens CORDIC
// Pipelined rotation-mode CORDIC giving cosine and sine of a phase in turns,
// one rotation per stage, then a clamp and quadrant mapping stage.
// ---------------------------------------------------------------------------
`default_nettype none

module hlf_cordic
	import hlf_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [31:0]        ang,
	output logic signed [31:0]      cos_val,
	output logic signed [31:0]      sin_val
);

	localparam int NI = (STAGES < 32) ? STAGES : 32;
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;
	localparam logic signed [33:0] ONE_P = 34'sd1073741824;
	localparam logic signed [33:0] ONE_N = -34'sd1073741824;

	logic signed [33:0] x_s [NI];
	logic signed [33:0] y_s [NI];
	logic signed [32:0] z_s [NI];
	logic [1:0]         q_s [NI];

	for (genvar i = 0; i < NI; i++) begin : g_it
		logic signed [33:0] xi;
		logic signed [33:0] yi;
		logic signed [32:0] zi;
		logic [1:0]         qi;
		if (i == 0) begin : g_first
			assign xi = 34'(CORDIC_GAIN);
			assign yi = '0;
			assign zi = $signed({3'b000, ang[29:0]});
			assign qi = ang[31:30];
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign qi = q_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[32]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - $signed({1'b0, atan_turn(i)});
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + $signed({1'b0, atan_turn(i)});
				end
				q_s[i] <= qi;
			end
		end
	end

	logic signed [33:0] xc;
	logic signed [33:0] yc;
	logic signed [33:0] cn;
	logic signed [33:0] sn;
	logic signed [31:0] cos_s;
	logic signed [31:0] sin_s;

	always_comb begin
		xc = (x_s[NI-1] > ONE_P) ? ONE_P : ((x_s[NI-1] < ONE_N) ? ONE_N : x_s[NI-1]);
		yc = (y_s[NI-1] > ONE_P) ? ONE_P : ((y_s[NI-1] < ONE_N) ? ONE_N : y_s[NI-1]);
		case (q_s[NI-1])
			QUAD_0: begin cn = xc;  sn = yc;  end
			QUAD_1: begin cn = -yc; sn = xc;  end
			QUAD_2: begin cn = -xc; sn = -yc; end
			QUAD_3: begin cn = yc;  sn = -xc; end
			default: begin cn = xc; sn = yc; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s <= 32'(cn);
			sin_s <= 32'(sn);
		end
	end

	assign cos_val = cos_s;
	assign sin_val = sin_s;

endmodule

`default_nettype wire

// ----- rtl/hlf_div.sv -----
// ---------------------------------------------------------------------------
// Harmonic lens divider
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit in 33 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module hlf_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [65:0] num,
	input  wire logic [31:0] den,
	output logic      [32:0] quo,
	output logic             ovf
);

	localparam int QB = 33;

	logic [31:0]   r_s [QB+1];
	logic [QB-1:0] lo_s [QB+1];
	logic [QB-1:0] q_s [QB+1];
	logic [31:0]   d_s [QB+1];
	logic          o_s [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			o_s[0]  <= num[65:33] >= {1'b0, den};
			r_s[0]  <= num[64:33];
			lo_s[0] <= num[32:0];
			q_s[0]  <= '0;
			d_s[0]  <= den;
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_st
		logic [32:0] t;
		logic        ge;
		assign t  = {r_s[i-1], lo_s[i-1][QB-1]};
		assign ge = t >= {1'b0, d_s[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i]  <= ge ? 32'(t - {1'b0, d_s[i-1]}) : t[31:0];
				lo_s[i] <= {lo_s[i-1][QB-2:0], 1'b0};
				q_s[i]  <= {q_s[i-1][QB-2:0], ge};
				d_s[i]  <= d_s[i-1];
				o_s[i]  <= o_s[i-1];
			end
		end
	end

	assign quo = q_s[QB];
	assign ovf = o_s[QB];

endmodule

`default_nettype wire
